// ----- rtl/slfr_pkg.sv -----
// Shared types, codes and constants of the servo link frame receiver.
package slfr_pkg;

    // Frame header bytes.
    localparam logic [7:0] HDR_FIRST  = 8'h81;
    localparam logic [7:0] HDR_SECOND = 8'hA1;

    // Message ids.
    localparam logic [7:0] ID_STATUS = 8'd10;
    localparam logic [7:0] ID_PULSE  = 8'd13;
    localparam logic [7:0] ID_AUX    = 8'd14;

    // Shortest payload that carries the fields of each frame type.
    localparam logic [7:0] STATUS_MIN_LEN = 8'd2;
    localparam logic [7:0] PULSE_MIN_LEN  = 8'd2;
    localparam logic [7:0] AUX_MIN_LEN    = 8'd4;

    // Mode field of the status frame sits in payload byte 1.
    localparam logic [7:0] MODE_FIELD_MASK = 8'h06;
    localparam logic [1:0] MODE_FIELD_NONE   = 2'd0;
    localparam logic [1:0] MODE_FIELD_MANUAL = 2'd1;

    // Pilot mode codes.
    localparam logic [1:0] MODE_UNKNOWN = 2'd0;
    localparam logic [1:0] MODE_MANUAL  = 2'd1;
    localparam logic [1:0] MODE_AUTO    = 2'd2;

    // Channel that always takes the width from payload bytes 0 and 1.
    localparam int PULSE_FIXED_CHANNEL = 7;

    // Configuration register indexes and reset values.
    localparam logic [7:0]  REG_PULSE_LOW  = 8'd0;
    localparam logic [7:0]  REG_PULSE_HIGH = 8'd1;
    localparam logic [15:0] PULSE_LOW_RESET  = 16'd800;
    localparam logic [15:0] PULSE_HIGH_RESET = 16'd2200;

    // Parameter defaults.
    localparam int DEFAULT_NUM_CHANNELS       = 9;
    localparam int DEFAULT_KEPT_PAYLOAD_BYTES = 16;

    // Bit widths of the packed output payload.
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 3;

    // Result kinds.
    typedef enum logic [2:0] {
        EV_BAD_CHECK  = 3'd0,
        EV_STATUS     = 3'd1,
        EV_NO_SIGNAL  = 3'd2,
        EV_CHANNEL    = 3'd3,
        EV_AUX_TIME   = 3'd4,
        EV_AUX_OVER   = 3'd5,
        EV_UNKNOWN_ID = 3'd6
    } event_t;

    // Byte parser phases.
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ID   = 3'd1,
        PH_LEN  = 3'd2,
        PH_PAY  = 3'd3,
        PH_CK1  = 3'd4,
        PH_CK2  = 3'd5
    } phase_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_RX   = 3'd0,
        S_RD   = 3'd1,
        S_WR   = 3'd2,
        S_CH7  = 3'd3,
        S_EMIT = 3'd4
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_byte;
        logic load_frame;
        logic pair_rd;
        logic chan_wr;
        logic ch7_wr;
        logic load_chan;
        logic last_chan;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ck2_phase;
        logic out_valid;
        logic single_result;
        logic pulse_start;
        logic pair_ok;
    } dp_status_t;

endpackage

// ----- rtl/slfr_ctrl.sv -----
// Controller state machine: byte intake, pulse channel update sequence and result run.
module slfr_ctrl
    import slfr_pkg::*;
#(
    parameter int NUM_CHANNELS = DEFAULT_NUM_CHANNELS,
    parameter int IDX_W        = $clog2(NUM_CHANNELS + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             m_tready,
    input  dp_status_t       sts,
    output dp_cmd_t          cmd,
    output logic [IDX_W-1:0] seq_idx
);

    ctrl_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // State and sequence counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RX;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign seq_idx = idx_reg;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_RX:
            begin
                // The final check byte waits until the result slot is free.
                s_tready = !(sts.ck2_phase && sts.out_valid);
                cmd.take_byte = s_tvalid && s_tready;
                if (cmd.take_byte && sts.ck2_phase)
                begin
                    cmd.load_frame = sts.single_result;
                    if (sts.pulse_start)
                    begin
                        state_next = S_RD;
                        idx_next   = IDX_W'(1);
                    end
                end
            end
            S_RD:
            begin
                if (sts.pair_ok)
                begin
                    cmd.pair_rd = 1'b1;
                    state_next  = S_WR;
                end
                else
                begin
                    state_next = S_CH7;
                end
            end
            S_WR:
            begin
                cmd.chan_wr = 1'b1;
                idx_next    = idx_reg + IDX_W'(1);
                state_next  = S_RD;
            end
            S_CH7:
            begin
                cmd.ch7_wr = 1'b1;
                idx_next   = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!sts.out_valid || m_tready)
                begin
                    cmd.load_chan = 1'b1;
                    cmd.last_chan = (idx_reg == IDX_W'(NUM_CHANNELS - 1));
                    if (cmd.last_chan)
                    begin
                        idx_next   = '0;
                        state_next = S_RX;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_RX;
            end
        endcase
    end

endmodule

// ----- rtl/slfr_dp.sv -----
// Datapath: byte parser, checksum, payload store, channel store, decode and output register.
module slfr_dp
    import slfr_pkg::*;
#(
    parameter int NUM_CHANNELS       = DEFAULT_NUM_CHANNELS,
    parameter int KEPT_PAYLOAD_BYTES = DEFAULT_KEPT_PAYLOAD_BYTES,
    parameter int IDX_W              = $clog2(NUM_CHANNELS + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             in_byte,
    input  dp_cmd_t                cmd,
    input  logic [IDX_W-1:0]       seq_idx,
    output dp_status_t             sts,
    input  logic                   cfg_valid,
    input  logic [7:0]             cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [OUT_TUSER_W-1:0] m_tuser,
    output logic                   m_tlast
);

    localparam int PAIRS = KEPT_PAYLOAD_BYTES / 2;
    localparam int PW    = $clog2(PAIRS);
    localparam int LIMIT = (NUM_CHANNELS < PAIRS) ? NUM_CHANNELS : PAIRS;
    localparam int CH_W  = $clog2(NUM_CHANNELS);

    // Parser and checksum state.
    phase_t      phase_reg;
    logic        armed_reg;
    logic [7:0]  id_reg;
    logic [7:0]  len_reg;
    logic [7:0]  bidx_reg;
    logic [7:0]  sum_lo_reg;
    logic [7:0]  sum_hi_reg;
    logic [7:0]  check_reg;

    // Payload keep: first four bytes at fixed places, first PAIRS full pairs in a memory.
    logic [7:0]  head_reg [4];
    logic [7:0]  hi_byte_reg;
    logic [15:0] pair_mem [PAIRS];
    logic [15:0] pair_q;

    // Configuration, channel store and pilot mode.
    logic [15:0] low_reg;
    logic [15:0] high_reg;
    logic [15:0] chan_reg [NUM_CHANNELS];
    logic [1:0]  pilot_reg;

    // Output register.
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TUSER_W-1:0] out_user_reg;
    logic                   out_last_reg;

    logic [7:0]  sum_lo_add;
    logic [7:0]  bidx_inc;
    logic [6:0]  pair_idx;
    logic        good;
    logic        is_status;
    logic        is_pulse;
    logic        is_aux;
    logic        is_other;
    logic [1:0]  mode_field;
    logic [1:0]  mode_new;
    logic        status_update;
    event_t      frame_ev;
    logic [1:0]  frame_pilot;
    logic        frame_changed;
    logic [13:0] frame_time;

    assign sum_lo_add = sum_lo_reg + in_byte;
    assign bidx_inc   = bidx_reg + 8'd1;
    assign pair_idx   = bidx_reg[7:1];

    // Byte parser and running checksum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            armed_reg  <= 1'b0;
            id_reg     <= '0;
            len_reg    <= '0;
            bidx_reg   <= '0;
            sum_lo_reg <= '0;
            sum_hi_reg <= '0;
            check_reg  <= '0;
        end
        else if (cmd.take_byte)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    armed_reg <= (in_byte == HDR_FIRST);
                    if (in_byte != HDR_FIRST && in_byte == HDR_SECOND && armed_reg)
                    begin
                        phase_reg <= PH_ID;
                    end
                end
                PH_ID:
                begin
                    id_reg    <= in_byte;
                    phase_reg <= PH_LEN;
                end
                PH_LEN:
                begin
                    len_reg    <= in_byte;
                    bidx_reg   <= '0;
                    sum_lo_reg <= id_reg + in_byte;
                    sum_hi_reg <= {id_reg[6:0], 1'b0} + in_byte;
                    phase_reg  <= (in_byte == 8'd0) ? PH_CK1 : PH_PAY;
                end
                PH_PAY:
                begin
                    sum_lo_reg <= sum_lo_add;
                    sum_hi_reg <= sum_hi_reg + sum_lo_add;
                    bidx_reg   <= bidx_inc;
                    if (bidx_inc >= len_reg)
                    begin
                        phase_reg <= PH_CK1;
                    end
                end
                PH_CK1:
                begin
                    check_reg <= in_byte;
                    phase_reg <= PH_CK2;
                end
                PH_CK2:
                begin
                    phase_reg <= PH_HUNT;
                    armed_reg <= 1'b0;
                end
                default:
                begin
                    phase_reg <= PH_HUNT;
                    armed_reg <= 1'b0;
                end
            endcase
        end
    end

    // Payload keep; written only by bytes of the current frame.
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte && phase_reg == PH_PAY)
        begin
            if (bidx_reg < 8'd4)
            begin
                head_reg[bidx_reg[1:0]] <= in_byte;
            end
            if (!bidx_reg[0])
            begin
                hi_byte_reg <= in_byte;
            end
            else if (pair_idx < 7'(PAIRS))
            begin
                pair_mem[PW'(pair_idx)] <= {hi_byte_reg, in_byte};
            end
        end
        if (cmd.pair_rd)
        begin
            pair_q <= pair_mem[PW'(seq_idx)];
        end
    end

    // Frame checks and decode of single-result frames.
    assign good       = (check_reg == sum_lo_reg) && (in_byte == sum_hi_reg);
    assign is_status  = (id_reg == ID_STATUS);
    assign is_pulse   = (id_reg == ID_PULSE);
    assign is_aux     = (id_reg == ID_AUX);
    assign is_other   = !is_status && !is_pulse && !is_aux;
    assign mode_field = 2'((head_reg[1] & MODE_FIELD_MASK) >> 1);
    assign mode_new   = (mode_field == MODE_FIELD_MANUAL) ? MODE_MANUAL : MODE_AUTO;
    assign status_update = cmd.load_frame && good && is_status
                           && (len_reg >= STATUS_MIN_LEN) && (mode_field != MODE_FIELD_NONE);

    always_comb
    begin
        frame_ev      = EV_UNKNOWN_ID;
        frame_pilot   = pilot_reg;
        frame_changed = 1'b0;
        frame_time    = '0;
        if (!good)
        begin
            frame_ev = EV_BAD_CHECK;
        end
        else if (is_status)
        begin
            if (mode_field == MODE_FIELD_NONE)
            begin
                frame_ev = EV_NO_SIGNAL;
            end
            else
            begin
                frame_ev      = EV_STATUS;
                frame_pilot   = mode_new;
                frame_changed = (mode_new != pilot_reg);
            end
        end
        else if (is_aux)
        begin
            if (head_reg[2][7])
            begin
                frame_ev = EV_AUX_OVER;
            end
            else
            begin
                frame_ev   = EV_AUX_TIME;
                frame_time = {head_reg[2][5:0], head_reg[3]};
            end
        end
    end

    assign sts.ck2_phase     = (phase_reg == PH_CK2);
    assign sts.out_valid     = out_valid_reg;
    assign sts.single_result = !good || is_other
                               || (is_status && len_reg >= STATUS_MIN_LEN)
                               || (is_aux && len_reg >= AUX_MIN_LEN);
    assign sts.pulse_start   = good && is_pulse && (len_reg >= PULSE_MIN_LEN);
    assign sts.pair_ok       = (8'(seq_idx) < {1'b0, len_reg[7:1]})
                               && (seq_idx < IDX_W'(LIMIT));

    // Configuration registers; writes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= PULSE_LOW_RESET;
            high_reg <= PULSE_HIGH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PULSE_LOW:  low_reg  <= cfg_data;
                REG_PULSE_HIGH: high_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Channel store and pilot mode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                chan_reg[i] <= '0;
            end
            pilot_reg <= MODE_UNKNOWN;
        end
        else
        begin
            if (cmd.chan_wr && pair_q > low_reg && pair_q < high_reg)
            begin
                chan_reg[CH_W'(seq_idx - IDX_W'(1))] <= pair_q;
            end
            if (cmd.ch7_wr)
            begin
                chan_reg[CH_W'(PULSE_FIXED_CHANNEL)] <= {head_reg[0], head_reg[1]};
            end
            if (status_update)
            begin
                pilot_reg <= mode_new;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_frame || cmd.load_chan)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload; tdata from bit 0: id, mode, changed, channel, width, time.
    always_ff @(posedge clk)
    begin
        if (cmd.load_frame)
        begin
            out_user_reg <= frame_ev;
            out_data_reg <= {3'b000, frame_time, 16'd0, 4'd0,
                             frame_changed, frame_pilot, id_reg};
            out_last_reg <= 1'b1;
        end
        else if (cmd.load_chan)
        begin
            out_user_reg <= EV_CHANNEL;
            out_data_reg <= {3'b000, 14'd0, chan_reg[CH_W'(seq_idx)], 4'(seq_idx),
                             1'b0, pilot_reg, id_reg};
            out_last_reg <= cmd.last_chan;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/servo_link_frame_receiver.sv -----
// A single-result frame shows its result in the cycle after its second check byte is taken.
// A pulse frame checks pairs 1 up to min(channels, kept bytes/2, payload bytes/2) minus one,
// each in a read and a write state, writes channel 7, then loads one channel result
// per cycle as the sink takes them. Throughput: one byte per cycle; intake pauses during a
// channel run and holds the second check byte while an earlier result still waits. Reset:
// parser, limits, channel store and pilot mode return to defaults at once; no clear pass.
module servo_link_frame_receiver
    import slfr_pkg::*;
#(
    parameter int NUM_CHANNELS       = DEFAULT_NUM_CHANNELS,
    parameter int KEPT_PAYLOAD_BYTES = DEFAULT_KEPT_PAYLOAD_BYTES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // message_id[7:0], op_mode[9:8], mode_changed[10], channel[14:11],
    // pwm_width[30:15], time_count[44:31], zero pad[47:45]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [OUT_TUSER_W-1:0] m_tuser,   // event_res[2:0]
    output logic                   m_tlast,   // last
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [7:0]             cfg_index,
    input  logic [15:0]            cfg_data
);

    localparam int IDX_W = $clog2(NUM_CHANNELS + 1);

    dp_cmd_t          cmd;
    dp_status_t       sts;
    logic [IDX_W-1:0] seq_idx;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    slfr_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd),
        .seq_idx  (seq_idx)
    );

    slfr_dp #(
        .NUM_CHANNELS       (NUM_CHANNELS),
        .KEPT_PAYLOAD_BYTES (KEPT_PAYLOAD_BYTES),
        .IDX_W              (IDX_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (s_tdata),
        .cmd       (cmd),
        .seq_idx   (seq_idx),
        .sts       (sts),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- bench/tb_servo_link_frame_receiver.sv -----
// Self-checking testbench of the servo link frame receiver: byte stream in, result stream out.
`timescale 1ns / 1ps

module tb_servo_link_frame_receiver;
    import slfr_pkg::*;

    localparam int NCH          = DEFAULT_NUM_CHANNELS;
    localparam int KEPT         = DEFAULT_KEPT_PAYLOAD_BYTES;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_BYTES  = 8;

    // Ways to corrupt the check bytes of a frame.
    localparam logic [1:0] SPOIL_NONE   = 2'd0;
    localparam logic [1:0] SPOIL_FIRST  = 2'd1;
    localparam logic [1:0] SPOIL_SECOND = 2'd2;

    // One expected result request.
    typedef struct {
        event_t      ev;
        logic [7:0]  id;
        logic [1:0]  mode;
        logic        chg;
        logic [3:0]  chan;
        logic [15:0] width;
        logic [13:0] tcount;
        logic        fin;
    } frame_result_t;

    // One directed frame. Payload bytes 0..3 come from w01 and w23 (high byte first);
    // byte k beyond that is a byte of the word fill + k/2.
    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  len;
        logic [1:0]  lead;
        logic        noisy;
        logic [1:0]  spoil;
        logic [15:0] w01;
        logic [15:0] w23;
        logic [15:0] fill;
        logic        typed;
        event_t      ev_want;
    } drill_row_t;

    localparam int DRILL_ROWS = 13;
    localparam drill_row_t DRILL [DRILL_ROWS] = '{
        '{ID_STATUS, 8'd2,   2'd2, 1'b0, SPOIL_NONE,   16'h0002, 16'h0000, 16'd0,    1'b1,
          EV_STATUS},
        '{ID_STATUS, 8'd2,   2'd0, 1'b1, SPOIL_NONE,   16'h0006, 16'h0000, 16'd0,    1'b1,
          EV_STATUS},
        '{ID_STATUS, 8'd2,   2'd0, 1'b0, SPOIL_NONE,   16'h00F9, 16'h0000, 16'd0,    1'b1,
          EV_NO_SIGNAL},
        '{ID_STATUS, 8'd1,   2'd0, 1'b0, SPOIL_NONE,   16'h0200, 16'h0000, 16'd0,    1'b0,
          EV_BAD_CHECK},
        '{ID_PULSE,  8'd2,   2'd0, 1'b0, SPOIL_NONE,   16'hFFFF, 16'h0000, 16'd0,    1'b0,
          EV_CHANNEL},
        '{ID_PULSE,  8'd20,  2'd0, 1'b0, SPOIL_NONE,   16'h0000, 16'd801,  16'd2196, 1'b0,
          EV_CHANNEL},
        '{ID_PULSE,  8'd6,   2'd1, 1'b0, SPOIL_NONE,   16'h1234, 16'd800,  16'd0,    1'b0,
          EV_CHANNEL},
        '{ID_AUX,    8'd4,   2'd0, 1'b0, SPOIL_NONE,   16'h0000, 16'h7FFF, 16'd0,    1'b1,
          EV_AUX_TIME},
        '{ID_AUX,    8'd4,   2'd0, 1'b0, SPOIL_NONE,   16'h0000, 16'h8000, 16'd0,    1'b1,
          EV_AUX_OVER},
        '{ID_AUX,    8'd3,   2'd0, 1'b0, SPOIL_NONE,   16'h0000, 16'h1234, 16'd0,    1'b0,
          EV_AUX_TIME},
        '{8'h00,     8'd0,   2'd0, 1'b0, SPOIL_NONE,   16'h0000, 16'h0000, 16'd0,    1'b1,
          EV_UNKNOWN_ID},
        '{ID_PULSE,  8'd4,   2'd0, 1'b0, SPOIL_FIRST,  16'h0100, 16'h0400, 16'd0,    1'b1,
          EV_BAD_CHECK},
        '{ID_STATUS, 8'd2,   2'd0, 1'b0, SPOIL_SECOND, 16'h0002, 16'h0000, 16'd0,    1'b1,
          EV_BAD_CHECK}
    };

    // Block ports.
    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'd0;
    logic [15:0] cfg_data  = 16'd0;

    // Predictor state of the parser, the decoder and the limit registers.
    phase_t      rx_phase   = PH_HUNT;
    logic        hunt_armed = 1'b0;
    logic [7:0]  cur_id     = 8'd0;
    logic [7:0]  cur_len    = 8'd0;
    logic [7:0]  pay_count  = 8'd0;
    logic [7:0]  fl_lo      = 8'd0;
    logic [7:0]  fl_hi      = 8'd0;
    logic [7:0]  ck_first   = 8'd0;
    logic [7:0]  kept [KEPT];
    logic [15:0] chan_width [NCH];
    logic [1:0]  mode_now   = MODE_UNKNOWN;
    logic [15:0] lim_lo     = PULSE_LOW_RESET;
    logic [15:0] lim_hi     = PULSE_HIGH_RESET;

    frame_result_t results_due [$];
    frame_result_t oldest_due;
    logic [7:0]    frame_body [$];

    int mismatches  = 0;
    int cycle_count = 0;
    int sent_bytes  = 0;
    int burst_left  = 0;
    int stall_pct   = 0;
    bit gaps_on     = 1'b1;

    servo_link_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Queue one expected result; frame id and pilot mode come from the current state.
    task automatic note_result(input event_t ev, input logic chg, input logic [3:0] chan,
                               input logic [15:0] width, input logic [13:0] tcount,
                               input logic fin);
        frame_result_t r;
        r.ev     = ev;
        r.id     = cur_id;
        r.mode   = mode_now;
        r.chg    = chg;
        r.chan   = chan;
        r.width  = width;
        r.tcount = tcount;
        r.fin    = fin;
        results_due.insert(results_due.size(), r);
    endtask

    // Decode a frame whose check bytes matched.
    task automatic decode_frame();
        logic [1:0]  field;
        logic [1:0]  next_mode;
        logic [15:0] w;
        int          i;
        if (cur_id == ID_STATUS)
        begin
            if (cur_len < STATUS_MIN_LEN)
                return;
            field = 2'((kept[1] & MODE_FIELD_MASK) >> 1);
            if (field == MODE_FIELD_NONE)
            begin
                note_result(EV_NO_SIGNAL, 1'b0, 4'd0, 16'd0, 14'd0, 1'b1);
            end
            else
            begin
                next_mode = (field == MODE_FIELD_MANUAL) ? MODE_MANUAL : MODE_AUTO;
                w[0] = (next_mode != mode_now);
                mode_now = next_mode;
                note_result(EV_STATUS, w[0], 4'd0, 16'd0, 14'd0, 1'b1);
            end
        end
        else if (cur_id == ID_PULSE)
        begin
            if (cur_len < PULSE_MIN_LEN)
                return;
            // Pairs after the first word update channels only inside the limits;
            // pairs past the kept payload bytes are skipped.
            for (i = 1; i < NCH && i < int'(cur_len / 2) && 2 * i + 1 < KEPT; i++)
            begin
                w = {kept[2 * i], kept[2 * i + 1]};
                if (w > lim_lo && w < lim_hi)
                    chan_width[i - 1] = w;
            end
            chan_width[PULSE_FIXED_CHANNEL] = {kept[0], kept[1]};
            for (i = 0; i < NCH; i++)
                note_result(EV_CHANNEL, 1'b0, 4'(i), chan_width[i], 14'd0, i == NCH - 1);
        end
        else if (cur_id == ID_AUX)
        begin
            if (cur_len < AUX_MIN_LEN)
                return;
            if (kept[2][7])
                note_result(EV_AUX_OVER, 1'b0, 4'd0, 16'd0, 14'd0, 1'b1);
            else
                note_result(EV_AUX_TIME, 1'b0, 4'd0, 16'd0, {kept[2][5:0], kept[3]}, 1'b1);
        end
        else
        begin
            note_result(EV_UNKNOWN_ID, 1'b0, 4'd0, 16'd0, 14'd0, 1'b1);
        end
    endtask

    // Advance the predicted parser by one accepted byte.
    task automatic absorb_byte(input logic [7:0] b);
        case (rx_phase)
            PH_HUNT:
            begin
                if (b == HDR_FIRST)
                begin
                    hunt_armed = 1'b1;
                end
                else if (b == HDR_SECOND && hunt_armed)
                begin
                    hunt_armed = 1'b0;
                    rx_phase   = PH_ID;
                end
                else
                begin
                    hunt_armed = 1'b0;
                end
            end
            PH_ID:
            begin
                cur_id   = b;
                rx_phase = PH_LEN;
            end
            PH_LEN:
            begin
                cur_len   = b;
                pay_count = 8'd0;
                fl_lo     = cur_id + b;
                fl_hi     = cur_id + cur_id + b;
                rx_phase  = (b == 8'd0) ? PH_CK1 : PH_PAY;
            end
            PH_PAY:
            begin
                if (pay_count < KEPT)
                    kept[pay_count] = b;
                fl_lo     = fl_lo + b;
                fl_hi     = fl_hi + fl_lo;
                pay_count = pay_count + 8'd1;
                if (pay_count >= cur_len)
                    rx_phase = PH_CK1;
            end
            PH_CK1:
            begin
                ck_first = b;
                rx_phase = PH_CK2;
            end
            PH_CK2:
            begin
                rx_phase   = PH_HUNT;
                hunt_armed = 1'b0;
                if (ck_first != fl_lo || b != fl_hi)
                    note_result(EV_BAD_CHECK, 1'b0, 4'd0, 16'd0, 14'd0, 1'b1);
                else
                    decode_frame();
            end
            default:
            begin
                rx_phase   = PH_HUNT;
                hunt_armed = 1'b0;
            end
        endcase
    endtask

    // Offer one byte in bursts with random gaps; called and returns at a falling edge.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (gaps_on && burst_left <= 0)
        begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            while (gap > 0)
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom);
                @(negedge clk);
                gap--;
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        burst_left--;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_byte(b);
        sent_bytes++;
        @(negedge clk);
    endtask

    // Send a whole frame built around frame_body, with optional extra header bytes
    // and a corrupted check byte.
    task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                              input logic [1:0] spoil, input int lead);
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        int         k;
        ck_a = id + len;
        ck_b = id + id + len;
        for (k = 0; k < int'(len); k++)
        begin
            ck_a = ck_a + frame_body[k];
            ck_b = ck_b + ck_a;
        end
        if (spoil == SPOIL_FIRST)
            ck_a = ck_a ^ 8'h01;
        else if (spoil == SPOIL_SECOND)
            ck_b = ck_b ^ 8'h80;
        repeat (lead)
            send_byte(HDR_FIRST);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(id);
        send_byte(len);
        for (k = 0; k < int'(len); k++)
            send_byte(frame_body[k]);
        send_byte(ck_a);
        send_byte(ck_b);
    endtask

    // Let the block run dry: nothing owed, and time for frames that give no result.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    // Write one limit register request; called and returns at a falling edge.
    task automatic write_limit(input logic [7:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_PULSE_LOW)
            lim_lo = value;
        else if (idx == REG_PULSE_HIGH)
            lim_hi = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Result sink stalls at a rate that changes from phase to phase.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Compare each accepted result request with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual event %0d id %0d",
                         $time, m_tuser, m_tdata[7:0]);
                mismatches++;
            end
            else
            begin
                oldest_due = results_due.pop_front();
                check_field("event", oldest_due.ev, m_tuser);
                check_field("message_id", oldest_due.id, m_tdata[7:0]);
                check_field("op_mode", oldest_due.mode, m_tdata[9:8]);
                check_field("mode_changed", oldest_due.chg, m_tdata[10]);
                check_field("channel", oldest_due.chan, m_tdata[14:11]);
                check_field("pwm_width", oldest_due.width, m_tdata[30:15]);
                check_field("time_count", oldest_due.tcount, m_tdata[44:31]);
                check_field("last", oldest_due.fin, m_tlast);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus: directed frames at the reset limits, then random phases with rewritten limits.
    initial
    begin
        drill_row_t  row;
        logic [15:0] word;
        logic [7:0]  id;
        logic [7:0]  len;
        logic [1:0]  spoil;
        int          r;
        int          k;
        int          phase;
        int          start_bytes;
        int          roll;

        foreach (chan_width[i])
            chan_width[i] = 16'd0;
        foreach (kept[i])
            kept[i] = 8'd0;

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames.
        stall_pct = 25;
        for (r = 0; r < DRILL_ROWS; r++)
        begin
            row = DRILL[r];
            frame_body.delete();
            for (k = 0; k < int'(row.len); k++)
            begin
                if (k < 2)
                    frame_body.insert(frame_body.size(), k == 0 ? row.w01[15:8] : row.w01[7:0]);
                else if (k < 4)
                    frame_body.insert(frame_body.size(), k == 2 ? row.w23[15:8] : row.w23[7:0]);
                else
                begin
                    word = row.fill + 16'(k / 2);
                    frame_body.insert(frame_body.size(), k % 2 == 0 ? word[15:8] : word[7:0]);
                end
            end
            // Stray bytes that must not open a frame.
            if (row.noisy)
            begin
                send_byte(HDR_SECOND);
                send_byte(HDR_FIRST);
                send_byte(8'h55);
                send_byte(HDR_SECOND);
            end
            send_frame(row.id, row.len, row.spoil, int'(row.lead));
            if (row.typed)
                results_due[results_due.size() - 1].ev = row.ev_want;
        end

        // Random phases, each under its own limits and handshake pressure.
        for (phase = 0; phase < 4; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    write_limit(REG_PULSE_LOW, 16'd0);
                    write_limit(REG_PULSE_HIGH, 16'hFFFF);
                    stall_pct = 0;
                    gaps_on   = 1'b0;
                end
                1:
                begin
                    write_limit(REG_PULSE_LOW, 16'hFFFF);
                    write_limit(REG_PULSE_HIGH, 16'd0);
                    write_limit(8'($urandom_range(2, 255)), 16'($urandom));
                    stall_pct = 40;
                    gaps_on   = 1'b1;
                end
                2:
                begin
                    word = 16'($urandom_range(0, 30000));
                    write_limit(REG_PULSE_LOW, word);
                    write_limit(REG_PULSE_HIGH, word + 16'($urandom_range(2, 30000)));
                    stall_pct = 80;
                    gaps_on   = 1'b1;
                end
                default:
                begin
                    write_limit(REG_PULSE_HIGH, PULSE_HIGH_RESET);
                    write_limit(REG_PULSE_LOW, PULSE_LOW_RESET);
                    write_limit(8'd255, 16'hFFFF);
                    stall_pct = 10;
                    gaps_on   = 1'b1;
                end
            endcase

            start_bytes = sent_bytes;
            while (sent_bytes - start_bytes < PHASE_BYTES)
            begin
                roll  = $urandom_range(0, 99);
                spoil = ($urandom_range(0, 9) == 0) ? SPOIL_FIRST + 2'($urandom_range(0, 1))
                                                    : SPOIL_NONE;
                frame_body.delete();
                if (roll < 85)
                begin
                    // Well-formed frame with random content.
                    if (roll < 25)
                    begin
                        id  = ID_STATUS;
                        len = 8'($urandom_range(0, 4));
                    end
                    else if (roll < 55)
                    begin
                        id  = ID_PULSE;
                        len = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(21, 40))
                                                           : 8'($urandom_range(0, 20));
                    end
                    else if (roll < 72)
                    begin
                        id  = ID_AUX;
                        len = 8'($urandom_range(2, 6));
                    end
                    else
                    begin
                        id  = 8'($urandom);
                        len = 8'($urandom_range(0, 6));
                    end
                    // Pulse words land inside or on the limits about half the time.
                    for (k = 0; k < int'(len); k += 2)
                    begin
                        if (id == ID_PULSE && $urandom_range(0, 1) == 1)
                            word = 16'($urandom_range(lim_hi, lim_lo));
                        else
                            word = 16'($urandom);
                        frame_body.insert(frame_body.size(), word[15:8]);
                        if (k + 1 < int'(len))
                            frame_body.insert(frame_body.size(), word[7:0]);
                    end
                    send_frame(id, len, spoil, $urandom_range(0, 3) == 0 ? 1 : 0);
                end
                else if (roll < 93)
                begin
                    // Line noise.
                    repeat ($urandom_range(1, 6))
                        send_byte(($urandom_range(0, 3) == 0) ? HDR_FIRST : 8'($urandom));
                end
                else
                begin
                    // Header and id with no proper tail; later bytes get swallowed.
                    send_byte(HDR_FIRST);
                    send_byte(HDR_SECOND);
                    send_byte(8'($urandom));
                    repeat ($urandom_range(0, 3))
                        send_byte(8'($urandom));
                end
            end
        end

        settle();
        if (mismatches == 0 && results_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
